### rtl/fsca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsca_pkg;

    localparam logic [29:0] INV_TWO_PI   = 30'd683565276;
    localparam logic [29:0] CORR_P       = 30'd966367642;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [30:0] UNIT_Q30     = 31'h4000_0000;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } turn_mag_t;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } amp_mag_t;

endpackage

`default_nettype wire

### rtl/fsca_phase.sv
`timescale 1ns / 1ps
`default_nettype none

module fsca_phase #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                kind,
    input  wire logic [31:0]         angle,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output fsca_pkg::turn_mag_t      out_word
);
    import fsca_pkg::*;

    localparam int STAGES = 5;
    localparam logic [62:0] RND = 63'(1) << (ANGLE_FRAC_BITS - 1);

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] adv;

    logic        neg0_reg, neg0_next, kind0_reg, kind0_next;
    logic [31:0] mag0_reg, mag0_next;
    logic        neg1_reg, neg1_next, kind1_reg, kind1_next;
    logic [61:0] prod1_reg, prod1_next;
    logic        neg2_reg, neg2_next, kind2_reg, kind2_next;
    logic [31:0] p2_reg, p2_next;
    logic [62:0] rnd_sum;
    logic [31:0] signed_p;
    logic [31:0] phase3_reg, phase3_next;
    turn_mag_t   word4_reg, word4_next;

    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        neg0_next  = angle[31];
        kind0_next = kind;
        mag0_next  = angle[31] ? (~angle + 32'd1) : angle;

        neg1_next  = neg0_reg;
        kind1_next = kind0_reg;
        prod1_next = mag0_reg * INV_TWO_PI;

        neg2_next  = neg1_reg;
        kind2_next = kind1_reg;
        rnd_sum    = {1'b0, prod1_reg} + RND;
        p2_next    = rnd_sum[ANGLE_FRAC_BITS +: 32];

        signed_p    = neg2_reg ? (32'd0 - p2_reg) : p2_reg;
        phase3_next = signed_p + (kind2_reg ? QUARTER_TURN : 32'd0);

        word4_next.neg = phase3_reg[31];
        word4_next.mag = phase3_reg[31] ? (32'd0 - phase3_reg) : phase3_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            neg0_reg  <= neg0_next;
            kind0_reg <= kind0_next;
            mag0_reg  <= mag0_next;
        end
        if (adv[1]) begin
            neg1_reg  <= neg1_next;
            kind1_reg <= kind1_next;
            prod1_reg <= prod1_next;
        end
        if (adv[2]) begin
            neg2_reg  <= neg2_next;
            kind2_reg <= kind2_next;
            p2_reg    <= p2_next;
        end
        if (adv[3]) begin
            phase3_reg <= phase3_next;
        end
        if (adv[4]) begin
            word4_reg <= word4_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_word  = word4_reg;

endmodule

`default_nettype wire

### rtl/fsca_poly.sv
`timescale 1ns / 1ps
`default_nettype none

module fsca_poly (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire fsca_pkg::turn_mag_t in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output fsca_pkg::amp_mag_t       out_word
);
    import fsca_pkg::*;

    localparam int STAGES = 9;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] neg_reg, neg_next;

    logic [31:0] a0_reg, a0_next, b0_reg, b0_next;
    logic [63:0] m1_reg, m1_next;
    logic [63:0] ysum;
    logic [33:0] yraw;
    logic [30:0] ym2_reg, ym2_next;
    logic [30:0] ym3_reg, ym3_next, om3_reg, om3_next;
    logic [30:0] ym4_reg, ym4_next;
    logic [61:0] qp4_reg, qp4_next;
    logic [62:0] qsum;
    logic [30:0] ym5_reg, ym5_next, q5_reg, q5_next;
    logic [30:0] ym6_reg, ym6_next;
    logic [60:0] cp6_reg, cp6_next;
    logic [61:0] csum;
    logic [30:0] ym7_reg, ym7_next;
    logic [29:0] c7_reg, c7_next;
    amp_mag_t    word8_reg, word8_next;

    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        neg_next = neg_reg;
        if (adv[0]) begin
            vld_next[0] = in_valid;
            neg_next[0] = in_word.neg;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
                neg_next[i] = neg_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
        neg_reg <= neg_next;
    end

    always_comb begin
        a0_next = in_word.mag;
        b0_next = HALF_TURN - in_word.mag;

        m1_next = a0_reg * b0_reg;

        ysum     = m1_reg + 64'h2000_0000;
        yraw     = ysum[63:30];
        ym2_next = (yraw > {3'b000, UNIT_Q30}) ? UNIT_Q30 : yraw[30:0];

        ym3_next = ym2_reg;
        om3_next = UNIT_Q30 - ym2_reg;

        ym4_next = ym3_reg;
        qp4_next = ym3_reg * om3_reg;

        ym5_next = ym4_reg;
        qsum     = {1'b0, qp4_reg} + 63'h2000_0000;
        q5_next  = qsum[60:30];

        ym6_next = ym5_reg;
        cp6_next = q5_reg * CORR_P;

        ym7_next = ym6_reg;
        csum     = {1'b0, cp6_reg} + 62'h8000_0000;
        c7_next  = csum[61:32];

        word8_next.neg = neg_reg[STAGES-2];
        word8_next.mag = ({1'b0, c7_reg} > ym7_reg) ? 31'd0 : (ym7_reg - {1'b0, c7_reg});
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a0_reg <= a0_next;
            b0_reg <= b0_next;
        end
        if (adv[1]) begin
            m1_reg <= m1_next;
        end
        if (adv[2]) begin
            ym2_reg <= ym2_next;
        end
        if (adv[3]) begin
            ym3_reg <= ym3_next;
            om3_reg <= om3_next;
        end
        if (adv[4]) begin
            ym4_reg <= ym4_next;
            qp4_reg <= qp4_next;
        end
        if (adv[5]) begin
            ym5_reg <= ym5_next;
            q5_reg  <= q5_next;
        end
        if (adv[6]) begin
            ym6_reg <= ym6_next;
            cp6_reg <= cp6_next;
        end
        if (adv[7]) begin
            ym7_reg <= ym7_next;
            c7_reg  <= c7_next;
        end
        if (adv[8]) begin
            word8_reg <= word8_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_word  = word8_reg;

endmodule

`default_nettype wire

### rtl/fast_sine_cosine_approx.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Ports                         Contents
// s_       in         s_tvalid s_tready s_tdata     tdata: angle; tuser: kind
//                     s_tuser
// m_       out        m_tvalid m_tready m_tdata     tdata: value, zero padded
//
// One word is accepted every cycle while the output is not stalled; each word passes
// through the angle reduction stages, the polynomial stages and the output register.
// Apart from output stalls, throughput is set by the pipeline alone, one multiplier stage per product.
// A synchronous reset empties every stage; payload registers are not cleared.
// A stall at the output holds the stage it reaches and lets earlier gaps close up.

module fast_sine_cosine_approx #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS   = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    input  wire logic [31:0]                               s_tdata,  // [31:0] angle
    input  wire logic [0:0]                                s_tuser,  // [0] kind
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    output logic [((OUT_FRAC_BITS + 9) / 8) * 8 - 1:0]     m_tdata   // value, then zeros
);
    import fsca_pkg::*;

    localparam int OUT_W  = OUT_FRAC_BITS + 2;
    localparam int DATA_W = ((OUT_FRAC_BITS + 9) / 8) * 8;
    localparam logic [31:0] RND_O = 32'(1) << (29 - OUT_FRAC_BITS);
    localparam logic [OUT_FRAC_BITS:0] LIM = (OUT_FRAC_BITS + 1)'(1) << OUT_FRAC_BITS;

    logic      ph_valid, ph_ready;
    turn_mag_t ph_word;
    logic      po_valid, po_ready;
    amp_mag_t  po_word;

    logic [31:0]            osum;
    logic [OUT_FRAC_BITS:0] o_full, o_clip;
    logic [OUT_W-1:0]       o_ext;
    logic [OUT_W-1:0]       value_reg, value_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    fsca_phase #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .kind     (s_tuser[0]),
        .angle    (s_tdata),
        .out_valid(ph_valid),
        .out_ready(ph_ready),
        .out_word (ph_word)
    );

    fsca_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (ph_valid),
        .in_ready (ph_ready),
        .in_word  (ph_word),
        .out_valid(po_valid),
        .out_ready(po_ready),
        .out_word (po_word)
    );

    assign po_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        osum       = {1'b0, po_word.mag} + RND_O;
        o_full     = osum[30 -: OUT_FRAC_BITS + 1];
        o_clip     = (o_full > LIM) ? LIM : o_full;
        o_ext      = {1'b0, o_clip};
        value_next = po_word.neg ? (~o_ext + OUT_W'(1)) : o_ext;

        m_tvalid_next = m_tvalid_reg;
        if (po_ready) begin
            m_tvalid_next = po_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (po_ready && po_valid) begin
            value_reg <= value_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(value_reg);

endmodule

`default_nettype wire

### rtl/fsca_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fsca_checker #(
    parameter int OUT_FRAC_BITS = 16
) (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_tready,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [((OUT_FRAC_BITS + 9) / 8) * 8 - 1:0] m_tdata
);
    localparam int OUT_W = OUT_FRAC_BITS + 2;
    localparam logic signed [OUT_W-1:0] POS_ONE = OUT_W'(1) << OUT_FRAC_BITS;
    localparam logic signed [OUT_W-1:0] NEG_ONE = -POS_ONE;

    // After a reset the pipeline is empty, so nothing is offered and input is taken.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("pipeline not empty after reset");

    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output word withdrawn while stalled");

    a_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[OUT_W-1:0]) <= POS_ONE)
                   && ($signed(m_tdata[OUT_W-1:0]) >= NEG_ONE)))
        else $error("output value outside plus or minus one");

endmodule

bind fast_sine_cosine_approx fsca_checker #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_fsca_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int WORDS_PER_PHASE = 230;
    localparam longint unsigned RECIP_TWO_PI = 64'd683565276;
    localparam longint unsigned CORR_GAIN = 64'd966367642;
    localparam logic [31:0] QUARTER = 32'h4000_0000;
    localparam logic [31:0] HALF = 32'h8000_0000;
    localparam int TX_IDLE [3] = '{34, 69, 0};
    localparam int RX_IDLE [3] = '{69, 34, 0};

    typedef enum logic [0:0] {
        KIND_SINE   = 1'b0,
        KIND_COSINE = 1'b1
    } wave_kind_e;

    typedef struct packed {
        wave_kind_e  kind;
        logic [31:0] angle;
        logic        known;
        logic [17:0] value;
    } angle_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;  // [31:0] angle
    logic [0:0]  s_tuser = '0;  // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;       // [17:0] value, [23:18] zeros

    logic [17:0] value_queue [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_left = 0;

    angle_row_t rows [18] = '{
        '{KIND_SINE,   32'h0000_0000, 1'b1, 18'd0},
        '{KIND_COSINE, 32'h0000_0000, 1'b1, 18'd65536},
        '{KIND_SINE,   32'h7FFF_FFFF, 1'b0, 18'd0},
        '{KIND_SINE,   32'h8000_0000, 1'b0, 18'd0},
        '{KIND_COSINE, 32'h7FFF_FFFF, 1'b0, 18'd0},
        '{KIND_COSINE, 32'h8000_0000, 1'b0, 18'd0},
        '{KIND_SINE,   32'h0000_0001, 1'b0, 18'd0},
        '{KIND_SINE,   32'hFFFF_FFFF, 1'b0, 18'd0},
        '{KIND_COSINE, 32'hFFFF_FFFF, 1'b0, 18'd0},
        '{KIND_SINE,   32'h0001_9220, 1'b0, 18'd0},
        '{KIND_SINE,   32'hFFFE_6DE0, 1'b0, 18'd0},
        '{KIND_COSINE, 32'h0003_243F, 1'b0, 18'd0},
        '{KIND_SINE,   32'h0003_243F, 1'b0, 18'd0},
        '{KIND_COSINE, 32'hFFFE_6DE0, 1'b0, 18'd0},
        '{KIND_SINE,   32'hAAAA_AAAA, 1'b0, 18'd0},
        '{KIND_COSINE, 32'h5555_5555, 1'b0, 18'd0},
        '{KIND_SINE,   32'h0003_243F, 1'b0, 18'd0},
        '{KIND_SINE,   32'h0000_860B, 1'b0, 18'd0}
    };

    fast_sine_cosine_approx #(
        .ANGLE_FRAC_BITS(16),
        .OUT_FRAC_BITS  (16)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    function automatic logic [31:0] turn_phase(wave_kind_e kind, logic [31:0] angle);
        logic [63:0] mag;
        logic [63:0] scaled;
        logic [31:0] phase;
        mag = angle[31] ? {32'd0, -angle} : {32'd0, angle};
        scaled = (mag * RECIP_TWO_PI + 64'd32768) >> 16;
        phase = scaled[31:0];
        if (angle[31]) begin
            phase = -phase;
        end
        if (kind == KIND_COSINE) begin
            phase = phase + QUARTER;
        end
        return phase;
    endfunction

    function automatic logic [17:0] sincos_value(wave_kind_e kind, logic [31:0] angle);
        logic [31:0] phase;
        logic [63:0] a;
        logic [63:0] ym;
        logic [63:0] q;
        logic [63:0] c;
        logic [63:0] r;
        logic [63:0] o;
        phase = turn_phase(kind, angle);
        a = phase[31] ? (64'd1 << 32) - {32'd0, phase} : {32'd0, phase};
        ym = (a * ((64'd1 << 31) - a) + (64'd1 << 29)) >> 30;
        if (ym > (64'd1 << 30)) begin
            ym = 64'd1 << 30;
        end
        q = (ym * ((64'd1 << 30) - ym) + (64'd1 << 29)) >> 30;
        c = (q * CORR_GAIN + (64'd1 << 31)) >> 32;
        r = (c > ym) ? 64'd0 : ym - c;
        o = (r + (64'd1 << 13)) >> 14;
        if (o > (64'd1 << 16)) begin
            o = 64'd1 << 16;
        end
        return phase[31] ? 18'(-o) : 18'(o);
    endfunction

    task automatic send_word(wave_kind_e kind, logic [31:0] angle, logic [17:0] want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = angle;
        do @(posedge aclk); while (!s_tready);
        value_queue.push_back(want);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (value_queue.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_tready = 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        logic [17:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (value_queue.size() == 0) begin
                $error("value: no word expected, got %0d", $signed(m_tdata[17:0]));
                fail_count++;
            end else begin
                want = value_queue.pop_front();
                if (m_tdata[17:0] !== want) begin
                    $error("value: expected %0d, got %0d", $signed(want),
                           $signed(m_tdata[17:0]));
                    fail_count++;
                end
                if (m_tdata[23:18] !== 6'd0) begin
                    $error("padding: expected %0h, got %0h", 6'd0, m_tdata[23:18]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        wave_kind_e  kind;
        logic [31:0] angle;
        logic [63:0] m;
        bit          found;

        // Look for an input that lands exactly on minus pi after the reduction.
        found = 1'b0;
        for (int k = 0; k < 6000 && !found; k++) begin
            for (int t = 1; t <= 3; t++) begin
                m = (((64'(k) << 32) + (64'(t) << 30)) << 16) / RECIP_TWO_PI;
                for (int d = 0; d <= 1; d++) begin
                    for (int c = 0; c < 4; c++) begin
                        angle = c[1] ? -32'(m + 64'(d)) : 32'(m + 64'(d));
                        kind = wave_kind_e'(c[0]);
                        if (!found && m + 64'(d) < 64'h8000_0000 &&
                            turn_phase(kind, angle) == HALF) begin
                            found = 1'b1;
                            rows[16] = '{kind, angle, 1'b1, 18'd0};
                        end
                    end
                end
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            send_word(rows[i].kind, rows[i].angle,
                      rows[i].known ? rows[i].value
                                    : sincos_value(rows[i].kind, rows[i].angle));
        end
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = TX_IDLE[ph];
            rx_idle_pct = RX_IDLE[ph];
            if (ph == 2) begin
                @(posedge aclk);
                rx_hold_left = HOLD_CYCLES;
                @(negedge aclk);
            end
            repeat (WORDS_PER_PHASE) begin
                kind = wave_kind_e'($urandom_range(1));
                case ($urandom_range(3))
                    0: angle = $urandom;
                    1: angle = 32'($urandom_range(3294192) - 1647096);
                    2: angle = 32'(($urandom_range(16) - 8) * 102944 +
                                   $urandom_range(8) - 4);
                    default: begin
                        angle = 32'($urandom_range(255));
                        if ($urandom_range(1) == 1) begin
                            angle = ~angle;
                        end
                    end
                endcase
                send_word(kind, angle, sincos_value(kind, angle));
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
